@@ rtl/core/plfd_pkg.sv @@
// ----------------------------------------------------------------------------
// plfd_pkg
// Shared constants and types for the point light falloff dither block.
// ----------------------------------------------------------------------------
package plfd_pkg;

  localparam int GAIN_BITS     = 24;
  localparam int DITHER_BITS   = 8;
  localparam int GREY_BITS     = 8;
  localparam int LEVEL_BITS    = 16;
  localparam int FRAC_BITS     = 8;
  localparam int SQRT_SHIFT    = 2 * FRAC_BITS;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 16'hFF00;
  localparam logic [GAIN_BITS-1:0]  GAIN_RST   = 24'd1854158;
  localparam int                    HEIGHT_RST = 54;
  localparam logic [GREY_BITS-1:0]  GREY_MAX   = 8'hFF;

  typedef enum logic {
    REG_HEIGHT = 1'b0,
    REG_GAIN   = 1'b1
  } cfg_reg_t;

endpackage

@@ rtl/core/plfd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// plfd_sqrt_cell
// One digit of a restoring square root: consumes two radicand bits per cell.
// ----------------------------------------------------------------------------
module plfd_sqrt_cell #(
  parameter int SQW    = 20,
  parameter int SIDE_W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_i,
  input  logic [2*SQW-1:0]    n_i,
  input  logic [SQW+1:0]      rem_i,
  input  logic [SQW-1:0]      root_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [2*SQW-1:0]    n_o,
  output logic [SQW+1:0]      rem_o,
  output logic [SQW-1:0]      root_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic [SQW+3:0] trial;
  logic [SQW+3:0] part;
  logic           take;
  logic           valid_r;
  logic [2*SQW-1:0] n_r;
  logic [SQW+1:0] rem_r;
  logic [SQW-1:0] root_r;
  logic [SIDE_W-1:0] side_r;

  assign part  = {rem_i, n_i[2*SQW-1 -: 2]};
  assign trial = (SQW+4)'({root_i, 2'b01});
  assign take  = (part >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= {n_i[2*SQW-3:0], 2'b00};
      side_r <= side_i;
      if (take) begin
        rem_r  <= (SQW+2)'(part - trial);
        root_r <= {root_i[SQW-2:0], 1'b1};
      end else begin
        rem_r  <= (SQW+2)'(part);
        root_r <= {root_i[SQW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = valid_r;
  assign n_o     = n_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;

endmodule

@@ rtl/core/plfd_div_cell.sv @@
// ----------------------------------------------------------------------------
// plfd_div_cell
// One quotient bit of a restoring divider; cells are chained from MSB down.
// ----------------------------------------------------------------------------
module plfd_div_cell #(
  parameter int DENW   = 44,
  parameter int QW     = 16,
  parameter int SH     = 15,
  parameter int SIDE_W = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [DENW+QW-1:0]   rem_i,
  input  logic [DENW-1:0]      den_i,
  input  logic [QW-1:0]        q_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [DENW+QW-1:0]   rem_o,
  output logic [DENW-1:0]      den_o,
  output logic [QW-1:0]        q_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int RW = DENW + QW;

  logic [RW-1:0]     dsh;
  logic              take;
  logic              valid_r;
  logic [RW-1:0]     rem_r;
  logic [DENW-1:0]   den_r;
  logic [QW-1:0]     q_r;
  logic [SIDE_W-1:0] side_r;

  assign dsh  = RW'(den_i) << SH;
  assign take = (rem_i >= dsh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= take ? (rem_i - dsh) : rem_i;
      den_r  <= den_i;
      q_r    <= {q_i[QW-2:0], take};
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign q_o     = q_r;
  assign side_o  = side_r;

endmodule

@@ rtl/core/point_light_falloff_dither.sv @@
// ----------------------------------------------------------------------------
// point_light_falloff_dither
// Inverse-square point light level with dithered 8-bit grey output.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock and returns one result per pixel in
// order. The pipe is two squaring/sum stages, one cell per root bit, the
// r2*S multiply and the saturation compare, one cell per level bit of the
// divider, and the output register. The whole pipe holds while the output
// waits. Register writes reach the scaled gain*height numerator used by the
// divider through the gz_r and num_r registers.
module point_light_falloff_dither #(
  parameter int COORD_BITS  = 12,
  parameter int HEIGHT_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // offset_x, offset_y, dither_threshold
  input  logic [((2*COORD_BITS+8+7)/8)*8-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // grey_level
  output logic [7:0]                             out_tdata,
  // clamped
  output logic                                   out_tuser,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [plfd_pkg::CFG_ADDR_BITS-1:0]     cfg_paddr,
  input  logic [plfd_pkg::CFG_DATA_BITS-1:0]     cfg_pwdata,
  output logic [plfd_pkg::CFG_DATA_BITS-1:0]     cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int C     = COORD_BITS;
  localparam int H     = HEIGHT_BITS;
  localparam int DB    = plfd_pkg::DITHER_BITS;
  localparam int QW    = plfd_pkg::LEVEL_BITS;
  localparam int SQMAX = (2*C > 2*H) ? 2*C : 2*H;
  localparam int R2W   = SQMAX + 1;
  localparam int SQW   = (R2W + plfd_pkg::SQRT_SHIFT + 1) / 2;
  localparam int NW    = 2 * SQW;
  localparam int DENW  = R2W + SQW;
  localparam int GZW   = plfd_pkg::GAIN_BITS + H;
  localparam int NUMW  = GZW + QW;
  localparam int RW    = DENW + QW;
  localparam int MXW   = (NUMW > RW) ? NUMW : RW;
  localparam int CMPW  = (GZW > DENW) ? GZW : DENW;
  localparam int SQS_W = DB + R2W;
  localparam int DVS_W = DB + 1;

  // configuration
  logic [H-1:0]                     height_r;
  logic [plfd_pkg::GAIN_BITS-1:0]   gain_r;
  logic [GZW-1:0]                   gz_r;
  logic [NUMW-1:0]                  num_r;
  logic                             cfg_wr;
  plfd_pkg::cfg_reg_t               cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_sel    = plfd_pkg::cfg_reg_t'(cfg_paddr[2]);

  always_comb begin
    case (cfg_sel)
      plfd_pkg::REG_HEIGHT: cfg_prdata = plfd_pkg::CFG_DATA_BITS'(height_r);
      plfd_pkg::REG_GAIN:   cfg_prdata = plfd_pkg::CFG_DATA_BITS'(gain_r);
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= H'(plfd_pkg::HEIGHT_RST);
      gain_r   <= plfd_pkg::GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        plfd_pkg::REG_HEIGHT: height_r <= cfg_pwdata[H-1:0];
        plfd_pkg::REG_GAIN:   gain_r   <= cfg_pwdata[plfd_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gz_r  <= GZW'(gain_r * height_r);
    num_r <= (NUMW'(gz_r) << QW) - (NUMW'(gz_r) << plfd_pkg::FRAC_BITS);
  end

  // pipeline control
  logic adv;
  logic out_valid_r;

  assign adv        = ~out_valid_r | out_tready;
  assign in_tready  = adv;

  // stage 1: magnitudes squared
  logic [C-1:0]  ox, oy, ax, ay;
  logic          s1_valid_r;
  logic [2*C-1:0] s1_xx_r, s1_yy_r;
  logic [2*H-1:0] s1_zz_r;
  logic [DB-1:0]  s1_dith_r;

  assign ox = in_tdata[C-1:0];
  assign oy = in_tdata[2*C-1:C];
  assign ax = ox[C-1] ? (~ox + C'(1)) : ox;
  assign ay = oy[C-1] ? (~oy + C'(1)) : oy;

  // stage 2: r2
  logic           s2_valid_r;
  logic [R2W-1:0] s2_r2_r;
  logic [DB-1:0]  s2_dith_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xx_r   <= ax * ax;
      s1_yy_r   <= ay * ay;
      s1_zz_r   <= height_r * height_r;
      s1_dith_r <= in_tdata[2*C+DB-1:2*C];
      s2_r2_r   <= R2W'(s1_xx_r) + R2W'(s1_yy_r) + R2W'(s1_zz_r);
      s2_dith_r <= s1_dith_r;
    end
  end

  // square root chain
  logic             sq_v    [0:SQW];
  logic [NW-1:0]    sq_n    [0:SQW];
  logic [SQW+1:0]   sq_rem  [0:SQW];
  logic [SQW-1:0]   sq_root [0:SQW];
  logic [SQS_W-1:0] sq_side [0:SQW];

  assign sq_v[0]    = s2_valid_r;
  assign sq_n[0]    = NW'({s2_r2_r, {plfd_pkg::SQRT_SHIFT{1'b0}}});
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {s2_dith_r, s2_r2_r};

  for (genvar i = 0; i < SQW; i++) begin : g_sqrt
    plfd_sqrt_cell #(
      .SQW    (SQW),
      .SIDE_W (SQS_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (sq_v[i]),
      .n_i     (sq_n[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_v[i+1]),
      .n_o     (sq_n[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // stage 3: denominator; stage 4: saturation check
  logic            s3_valid_r, s4_valid_r;
  logic [DENW-1:0] s3_den_r, s4_den_r;
  logic            s3_zero_r, s4_clamp_r;
  logic [DB-1:0]   s3_dith_r, s4_dith_r;
  logic [RW-1:0]   s4_rem_r;
  logic [MXW-1:0]  num_ext;
  logic            over;

  assign num_ext = MXW'(num_r);
  assign over    = CMPW'(gz_r) > CMPW'(s3_den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= sq_v[SQW];
      s4_valid_r <= s3_valid_r;
    end
  end

  // r2 of zero: unit denominator with zero numerator gives level zero
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_den_r   <= DENW'(sq_side[SQW][R2W-1:0] * sq_root[SQW]);
      s3_zero_r  <= (sq_side[SQW][R2W-1:0] == '0);
      s3_dith_r  <= sq_side[SQW][SQS_W-1:R2W];
      s4_den_r   <= s3_zero_r ? DENW'(1) : s3_den_r;
      s4_dith_r  <= s3_dith_r;
      s4_clamp_r <= ~s3_zero_r & over;
      s4_rem_r   <= (s3_zero_r | over) ? '0 : num_ext[RW-1:0];
    end
  end

  // divider chain
  logic             dv_v    [0:QW];
  logic [RW-1:0]    dv_rem  [0:QW];
  logic [DENW-1:0]  dv_den  [0:QW];
  logic [QW-1:0]    dv_q    [0:QW];
  logic [DVS_W-1:0] dv_side [0:QW];

  assign dv_v[0]    = s4_valid_r;
  assign dv_rem[0]  = s4_rem_r;
  assign dv_den[0]  = s4_den_r;
  assign dv_q[0]    = '0;
  assign dv_side[0] = {s4_clamp_r, s4_dith_r};

  for (genvar j = 0; j < QW; j++) begin : g_div
    plfd_div_cell #(
      .DENW   (DENW),
      .QW     (QW),
      .SH     (QW-1-j),
      .SIDE_W (DVS_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (dv_v[j]),
      .rem_i   (dv_rem[j]),
      .den_i   (dv_den[j]),
      .q_i     (dv_q[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_v[j+1]),
      .rem_o   (dv_rem[j+1]),
      .den_o   (dv_den[j+1]),
      .q_o     (dv_q[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // output stage
  logic [QW-1:0]  level;
  logic [DB-1:0]  dith;
  logic           clamp;
  logic [8:0]     grey_sum;
  logic [7:0]     grey_r;
  logic           clamp_r;

  assign clamp    = dv_side[QW][DB];
  assign dith     = dv_side[QW][DB-1:0];
  assign level    = clamp ? plfd_pkg::FULL_LEVEL : dv_q[QW];
  assign grey_sum = {1'b0, level[QW-1:plfd_pkg::FRAC_BITS]}
                  + 9'(level[plfd_pkg::FRAC_BITS-1:0] > dith);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grey_r  <= grey_sum[8] ? plfd_pkg::GREY_MAX : grey_sum[7:0];
      clamp_r <= clamp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = grey_r;
  assign out_tuser  = clamp_r;

endmodule

@@ tb/point_light_falloff_dither_test.sv @@
// ----------------------------------------------------------------------------
// point_light_falloff_dither_test
// Self-checking bench for the point light falloff dither block: directed pixel
// rows, then random pixels under several height/gain settings, with random
// idling on both stream sides, checked in order against an internal predictor.
// ----------------------------------------------------------------------------
module point_light_falloff_dither_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 12;
  localparam int HB = 10;
  localparam int LATENCY = 42;

  typedef struct packed {
    logic       clamped;
    logic [7:0] grey;
  } shade_t;

  typedef struct {
    logic signed [CB-1:0] dx;
    logic signed [CB-1:0] dy;
    logic [7:0]           dith;
    logic                 known;
    shade_t               want;
  } pixel_row_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0, out_tuser, cfg_pready;
  logic [31:0] in_tdata = '0;
  logic [7:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [plfd_pkg::CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;

  point_light_falloff_dither #(.COORD_BITS(CB), .HEIGHT_BITS(HB)) dut (.*);

  initial forever #6 clk = ~clk;
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  logic [HB-1:0] height_q = HB'(plfd_pkg::HEIGHT_RST);
  logic [23:0]   gain_q = plfd_pkg::GAIN_RST;
  shade_t        pending_shades[$];
  int            errors = 0, accepted = 0, shaded = 0, clamp_hits = 0;
  int            send_idle = 0, recv_idle = 0, hold_cycles = 0;

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic shade_t shade_pixel(input logic signed [CB-1:0] dx,
                                         input logic signed [CB-1:0] dy,
                                         input logic [7:0] dith);
    logic [63:0] ax, ay, r2, s, den, gz, lvl, g;
    shade_t o;
    ax = dx < 0 ? -64'(dx) : 64'(dx);
    ay = dy < 0 ? -64'(dy) : 64'(dy);
    r2 = ax * ax + ay * ay + 64'(height_q) * 64'(height_q);
    lvl = 0;
    o.clamped = 0;
    if (r2 != 0) begin
      s = root_floor(r2 << 16);
      den = r2 * s;
      gz = 64'(gain_q) * 64'(height_q);
      if (gz > den) begin
        lvl = 64'(plfd_pkg::FULL_LEVEL);
        o.clamped = 1;
      end else begin
        lvl = (64'(plfd_pkg::FULL_LEVEL) * gz) / den;
      end
    end
    g = lvl >> 8;
    if (lvl[7:0] > dith) g++;
    if (g > 255) g = 255;
    o.grey = g[7:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, shaded);
  endtask

  task automatic write_reg(input plfd_pkg::cfg_reg_t idx, input logic [31:0] val);
    in_tvalid <= 0;
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= plfd_pkg::CFG_ADDR_BITS'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (idx == plfd_pkg::REG_HEIGHT) height_q = val[HB-1:0];
    else gain_q = val[23:0];
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_pixel(input logic signed [CB-1:0] dx, input logic signed [CB-1:0] dy,
                            input logic [7:0] dith, input logic known, input shade_t want);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {dith, dy, dx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_shades.push_back(known ? want : shade_pixel(dx, dy, dith));
    accepted++;
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        shade_t w;
        shaded++;
        if (pending_shades.size() == 0) begin
          report_mismatch("unexpected transaction", out_tdata, 0);
        end else begin
          w = pending_shades.pop_front();
          if (out_tdata !== w.grey) report_mismatch("grey_level", out_tdata, w.grey);
          if (out_tuser !== w.clamped) report_mismatch("clamped", out_tuser, w.clamped);
          if (out_tuser === 1'b1) clamp_hits++;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 0;
      end else begin
        out_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic random_pixels(input int n);
    logic signed [CB-1:0] dx, dy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          dx = CB'($urandom);
          dy = CB'($urandom);
        end
        1: begin
          dx = CB'($signed($urandom_range(64)) - 32);
          dy = CB'($signed($urandom_range(64)) - 32);
        end
        default: begin
          dx = CB'($signed($urandom_range(512)) - 256);
          dy = CB'($signed($urandom_range(512)) - 256);
        end
      endcase
      send_pixel(dx, dy, 8'($urandom), 0, '0);
    end
  endtask

  pixel_row_t directed[] = '{
    '{12'sd0, 12'sd0, 8'd0, 1'b0, '0},
    '{12'sd0, 12'sd0, 8'd255, 1'b0, '0},
    '{-12'sd2048, -12'sd2048, 8'd0, 1'b0, '0},
    '{12'sd2047, 12'sd2047, 8'd255, 1'b0, '0},
    '{-12'sd2048, 12'sd2047, 8'd128, 1'b0, '0},
    '{12'sd1, -12'sd1, 8'd1, 1'b0, '0},
    '{12'sd54, 12'sd0, 8'd100, 1'b0, '0},
    '{12'sd0, -12'sd54, 8'd254, 1'b0, '0},
    '{12'sd1365, -12'sd682, 8'd85, 1'b0, '0},
    '{-12'sd1366, 12'sd681, 8'd170, 1'b0, '0}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i])
      send_pixel(directed[i].dx, directed[i].dy, directed[i].dith, 0, '0);
    drain();
    // zero height at the center: level zero
    write_reg(plfd_pkg::REG_HEIGHT, 32'd0);
    send_pixel(12'sd0, 12'sd0, 8'd0, 1, '{clamped: 1'b0, grey: 8'd0});
    send_pixel(12'sd100, -12'sd7, 8'd0, 0, '0);
    drain();
    // huge gain near the light: saturates
    write_reg(plfd_pkg::REG_HEIGHT, 32'd1);
    write_reg(plfd_pkg::REG_GAIN, 32'hFFFFFF);
    send_pixel(12'sd0, 12'sd0, 8'd0, 1, '{clamped: 1'b1, grey: 8'd255});
    send_pixel(-12'sd3, 12'sd2, 8'd255, 0, '0);
    drain();
    // exact full level: z=1, r2=1, S=256, G*z = 256 -> level 65280, not clamped
    write_reg(plfd_pkg::REG_GAIN, 32'd256);
    send_pixel(12'sd0, 12'sd0, 8'd0, 1, '{clamped: 1'b0, grey: 8'd255});
    drain();
    write_reg(plfd_pkg::REG_GAIN, 32'd0);
    send_pixel(12'sd0, 12'sd0, 8'd0, 1, '{clamped: 1'b0, grey: 8'd0});
    send_pixel(12'sd5, 12'sd5, 8'd9, 0, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(plfd_pkg::REG_HEIGHT, 32'd54);
          write_reg(plfd_pkg::REG_GAIN, 32'(plfd_pkg::GAIN_RST));
        end
        1: begin
          write_reg(plfd_pkg::REG_HEIGHT, 32'd1023);
          write_reg(plfd_pkg::REG_GAIN, 32'hFFFFFF);
        end
        2: begin
          write_reg(plfd_pkg::REG_HEIGHT, 32'd1);
          write_reg(plfd_pkg::REG_GAIN, 32'd3000);
        end
        3: begin
          write_reg(plfd_pkg::REG_HEIGHT, 32'd200);
          write_reg(plfd_pkg::REG_GAIN, 32'd9000000);
        end
        4: begin
          write_reg(plfd_pkg::REG_HEIGHT, 32'd20);
          write_reg(plfd_pkg::REG_GAIN, 32'd40000);
        end
        default: begin
          write_reg(plfd_pkg::REG_HEIGHT, $urandom_range(1023, 1));
          write_reg(plfd_pkg::REG_GAIN, $urandom_range(24'hFFFFFF));
        end
      endcase
      send_idle = phase < 2 ? 35 : (phase < 4 ? 61 : 0);
      recv_idle = phase < 2 ? 61 : (phase < 4 ? 35 : 0);
      if (phase == 4) hold_cycles = 300;
      random_pixels(200);
      drain();
    end

    $display("covered %0d pixels, %0d results, %0d saturated, over several light settings",
             accepted, shaded, clamp_hits);
    if (errors == 0 && pending_shades.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ point_light_falloff_dither.f @@
rtl/core/plfd_pkg.sv
rtl/core/plfd_sqrt_cell.sv
rtl/core/plfd_div_cell.sv
rtl/core/point_light_falloff_dither.sv
tb/point_light_falloff_dither_test.sv
